FILE: hdl/ebta_pkg.sv
package ebta_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned WidthW  = 13;
  localparam int unsigned HeightW = 13;
  localparam int unsigned RateW   = 8;
  localparam int unsigned VswW    = 10;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PclkW   = 18;
  localparam int unsigned HtotW   = 23;
  localparam int unsigned HsyncW  = 12;
  localparam int unsigned VtotW   = 18;

  localparam int unsigned DivW    = 28;  // dividend: pixel clock in Hz
  localparam int unsigned DvsrW   = 22;  // divisor: total times rate
  localparam int unsigned NvW     = 14;  // active height plus vertical blank
  localparam int unsigned HtW     = 12;
  localparam int unsigned VblankW = 6;
  localparam int unsigned ProdW   = 57;
  localparam int unsigned RecipW  = 29;

  // floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for any 32-bit x.
  localparam logic [RecipW-1:0] Recip1000 = 29'd274877907;
  localparam int unsigned RecipShift = 38;

  localparam logic [ModeW-1:0] ModeVblank   = 2'd0;
  localparam logic [ModeW-1:0] ModeHblank   = 2'd1;
  localparam logic [ModeW-1:0] ModeWireless = 2'd2;

  localparam logic [WidthW-1:0] MaxWidthSd  = 13'd720;
  localparam logic [WidthW-1:0] MaxWidthHd  = 13'd1280;
  localparam logic [WidthW-1:0] MaxWidthFhd = 13'd1920;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StWide     = 2'd1,
    StShort    = 2'd2,
    StZeroRate = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RefSd  = 2'd0,
    RefHd  = 2'd1,
    RefFhd = 2'd2,
    RefNone = 2'd3
  } ref_sel_e;

  typedef struct packed {
    logic [DivW-1:0]    pclk_hz;
    logic [HtW-1:0]     ht_vblank;
    logic [HtW-1:0]     ht_wireless;
    logic [HsyncW-1:0]  hsync;
    logic [VblankW-1:0] vblank;
  } ref_t;

  typedef struct packed {
    status_e            status;
    logic               hblank;
    logic [DivW-1:0]    dividend;
    logic [DvsrW-1:0]   divisor;
    logic [WidthW-1:0]  width;
    logic [HtW-1:0]     ht;
    logic [HsyncW-1:0]  hsync;
    logic [NvW-1:0]     nv;
    logic [VswW-1:0]    vsw;
  } fr_item_t;

  function automatic ref_t ref_lookup(ref_sel_e sel);
    ref_t r;
    unique case (sel)
      RefSd:   r = '{28'd74250000, 12'd900, 12'd900, 12'd760, 6'd30};
      RefHd:   r = '{28'd148500000, 12'd1800, 12'd1800, 12'd1390, 6'd30};
      RefFhd:  r = '{28'd148500000, 12'd2200, 12'd3000, 12'd2008, 6'd45};
      default: r = '{28'd148500000, 12'd2200, 12'd3000, 12'd2008, 6'd45};
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/ebta_if.sv
interface ebta_req_if;
  logic                          valid;
  logic                          ready;
  logic [ebta_pkg::ModeW-1:0]    mode;
  logic [ebta_pkg::WidthW-1:0]   active_width;
  logic [ebta_pkg::HeightW-1:0]  active_height;
  logic [ebta_pkg::RateW-1:0]    frame_rate;
  logic [ebta_pkg::VswW-1:0]     vsync_lines;

  modport source (output valid, mode, active_width, active_height, frame_rate, vsync_lines,
                  input ready);
  modport sink (input valid, mode, active_width, active_height, frame_rate, vsync_lines,
                output ready);
endinterface

interface ebta_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ebta_pkg::StatusW-1:0]  status;
  logic                          clock_written;
  logic [ebta_pkg::PclkW-1:0]    pixel_clock_khz;
  logic [ebta_pkg::HtotW-1:0]    horiz_total;
  logic [ebta_pkg::HsyncW-1:0]   hsync_begin;
  logic [ebta_pkg::VtotW-1:0]    vert_total;
  logic [ebta_pkg::VtotW-1:0]    vsync_begin;

  modport source (output valid, status, clock_written, pixel_clock_khz, horiz_total,
                  hsync_begin, vert_total, vsync_begin, input ready);
  modport sink (input valid, status, clock_written, pixel_clock_khz, horiz_total,
                hsync_begin, vert_total, vsync_begin, output ready);
endinterface

FILE: hdl/encoder_blank_timing_adjust_top.sv
// Channel | Port  | Role   | Payload
// request | req_i | sink   | mode, active_width, active_height, frame_rate, vsync_lines
// result  | rsp_o | source | status, clock_written, pixel_clock_khz, horiz_total,
//         |       |        | hsync_begin, vert_total, vsync_begin
//
// One item per cycle is taken and one result per cycle is given while the result is not stalled.
// An item passes in order through the front register, two-entry queue, divider input
// register, 28 divider stages (one quotient bit each), the reciprocal multiply stage and
// the output register.
// Reset clears only valid bits, queue pointers and count; no state carries between items.
// A stalled result holds the back end; the queue and front register keep taking items
// until they fill.
module encoder_blank_timing_adjust_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ebta_req_if.sink   req_i,
  ebta_rsp_if.source rsp_o
);

  ebta_pkg::fr_item_t fr_item, q_item;
  logic fr_valid, q_full, q_valid, bk_ready, push, pop;

  ebta_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .item_o  (fr_item),
    .valid_o (fr_valid),
    .ready_i (!q_full)
  );

  assign push = fr_valid && !q_full;
  assign pop  = q_valid && bk_ready;

  ebta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .item_o  (q_item),
    .valid_o (q_valid)
  );

  ebta_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (q_item),
    .valid_i (q_valid),
    .ready_o (bk_ready),
    .rsp_o   (rsp_o)
  );

endmodule

FILE: hdl/ebta_front.sv
module ebta_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ebta_req_if.sink           req_i,
  output ebta_pkg::fr_item_t item_o,
  output logic               valid_o,
  input  logic               ready_i
);

  ebta_pkg::ref_sel_e sel;
  ebta_pkg::ref_t     rf;
  ebta_pkg::fr_item_t item_d, item_q;
  logic               valid_q;
  logic               accept;

  always_comb begin
    if (req_i.active_width <= ebta_pkg::MaxWidthSd) begin
      sel = ebta_pkg::RefSd;
    end else if (req_i.active_width <= ebta_pkg::MaxWidthHd) begin
      sel = ebta_pkg::RefHd;
    end else if (req_i.active_width <= ebta_pkg::MaxWidthFhd) begin
      sel = ebta_pkg::RefFhd;
    end else begin
      sel = ebta_pkg::RefNone;
    end
  end

  assign rf = ebta_pkg::ref_lookup(sel);

  always_comb begin
    item_d.hblank   = (req_i.mode == ebta_pkg::ModeHblank);
    item_d.dividend = rf.pclk_hz;
    item_d.width    = req_i.active_width;
    item_d.hsync    = rf.hsync;
    item_d.vsw      = req_i.vsync_lines;
    item_d.nv       = ebta_pkg::NvW'(req_i.active_height) + ebta_pkg::NvW'(rf.vblank);
    // Mode 3 falls through to the wireless totals.
    item_d.ht       = (req_i.mode == ebta_pkg::ModeVblank) ? rf.ht_vblank : rf.ht_wireless;
    if (item_d.hblank) begin
      item_d.divisor = ebta_pkg::DvsrW'(item_d.nv) * ebta_pkg::DvsrW'(req_i.frame_rate);
    end else begin
      item_d.divisor = ebta_pkg::DvsrW'(item_d.ht) * ebta_pkg::DvsrW'(req_i.frame_rate);
    end
    if (sel == ebta_pkg::RefNone) begin
      item_d.status = ebta_pkg::StWide;
    end else if (req_i.frame_rate == '0) begin
      item_d.status = ebta_pkg::StZeroRate;
    end else begin
      item_d.status = ebta_pkg::StOk;
    end
  end

  assign req_i.ready = !valid_q || ready_i;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

FILE: hdl/ebta_fifo.sv
module ebta_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ebta_pkg::fr_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output ebta_pkg::fr_item_t item_o,
  output logic               valid_o
);

  ebta_pkg::fr_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: hdl/ebta_back.sv
module ebta_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ebta_pkg::fr_item_t item_i,
  input  logic               valid_i,
  output logic               ready_o,
  ebta_rsp_if.source         rsp_o
);

  localparam int unsigned Stages = ebta_pkg::DivW;

  logic                       en;
  logic [Stages:0]            sv_q;
  ebta_pkg::fr_item_t         sd_q  [Stages+1];
  logic [ebta_pkg::DvsrW-1:0] rem_q [Stages+1];
  logic [ebta_pkg::DivW-1:0]  quo_q [Stages+1];
  logic [ebta_pkg::DvsrW-1:0] rem_d [Stages+1];
  logic [ebta_pkg::DivW-1:0]  quo_d [Stages+1];

  logic                       mv_q;
  ebta_pkg::fr_item_t         md_q;
  logic [ebta_pkg::DivW-1:0]  mquo_q;
  logic [ebta_pkg::ProdW-1:0] mprod_q;
  logic [ebta_pkg::DivW-1:0]  exact;
  logic [ebta_pkg::ProdW-1:0] prod_d;

  logic                        out_v_q;
  ebta_pkg::status_e           st_d, st_q;
  logic                        cw_d, cw_q;
  logic [ebta_pkg::PclkW-1:0]  pclk_d, pclk_q;
  logic [ebta_pkg::HtotW-1:0]  htot_d, htot_q;
  logic [ebta_pkg::HsyncW-1:0] hs_d, hs_q;
  logic [ebta_pkg::VtotW-1:0]  vtot_d, vtot_q, vtot_sel;
  logic [ebta_pkg::VtotW-1:0]  vs_d, vs_q, sub;

  // The whole back end moves together; it holds only when a result waits.
  assign en      = !out_v_q || rsp_o.ready;
  assign ready_o = en;

  // One restoring quotient bit per stage, most significant bit first.
  always_comb begin
    logic [ebta_pkg::DvsrW:0] trial;
    rem_d[0] = '0;
    quo_d[0] = '0;
    for (int s = 0; s < Stages; s++) begin
      trial = {rem_q[s], sd_q[s].dividend[Stages-1-s]};
      if (trial >= {1'b0, sd_q[s].divisor}) begin
        rem_d[s+1] = ebta_pkg::DvsrW'(trial - {1'b0, sd_q[s].divisor});
        quo_d[s+1] = {quo_q[s][ebta_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d[s+1] = ebta_pkg::DvsrW'(trial);
        quo_d[s+1] = {quo_q[s][ebta_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  // quotient * divisor is the dividend less the remainder.
  assign exact  = sd_q[Stages].dividend - ebta_pkg::DivW'(rem_q[Stages]);
  assign prod_d = ebta_pkg::ProdW'(exact) * ebta_pkg::ProdW'(ebta_pkg::Recip1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q    <= '0;
      mv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sv_q    <= {sv_q[Stages-1:0], valid_i};
      mv_q    <= sv_q[Stages];
      out_v_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0]  <= item_i;
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      for (int s = 0; s < Stages; s++) begin
        sd_q[s+1]  <= sd_q[s];
        rem_q[s+1] <= rem_d[s+1];
        quo_q[s+1] <= quo_d[s+1];
      end
      md_q    <= sd_q[Stages];
      mquo_q  <= quo_q[Stages];
      mprod_q <= prod_d;
      st_q    <= st_d;
      cw_q    <= cw_d;
      pclk_q  <= pclk_d;
      htot_q  <= htot_d;
      hs_q    <= hs_d;
      vtot_q  <= vtot_d;
      vs_q    <= vs_d;
    end
  end

  assign vtot_sel = md_q.hblank ? ebta_pkg::VtotW'(md_q.nv) : mquo_q[ebta_pkg::VtotW-1:0];
  assign sub      = ebta_pkg::VtotW'(md_q.vsw) + ebta_pkg::VtotW'(4);

  always_comb begin
    st_d   = md_q.status;
    cw_d   = 1'b0;
    pclk_d = '0;
    htot_d = '0;
    hs_d   = '0;
    vtot_d = '0;
    vs_d   = '0;
    if (md_q.status == ebta_pkg::StOk) begin
      if (md_q.hblank && (mquo_q <= ebta_pkg::DivW'(md_q.width))) begin
        st_d = ebta_pkg::StShort;
      end else begin
        hs_d   = md_q.hsync;
        vtot_d = vtot_sel;
        vs_d   = (vtot_sel > sub) ? (vtot_sel - sub) : '0;
        if (md_q.hblank) begin
          htot_d = mquo_q[ebta_pkg::HtotW-1:0];
        end else begin
          htot_d = ebta_pkg::HtotW'(md_q.ht);
          cw_d   = 1'b1;
          pclk_d = mprod_q[ebta_pkg::RecipShift +: ebta_pkg::PclkW];
        end
      end
    end
  end

  assign rsp_o.valid           = out_v_q;
  assign rsp_o.status          = st_q;
  assign rsp_o.clock_written   = cw_q;
  assign rsp_o.pixel_clock_khz = pclk_q;
  assign rsp_o.horiz_total     = htot_q;
  assign rsp_o.hsync_begin     = hs_q;
  assign rsp_o.vert_total      = vtot_q;
  assign rsp_o.vsync_begin     = vs_q;

endmodule

FILE: hdl/ebta_checker.sv
module ebta_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ebta_pkg::StatusW-1:0] status,
  input logic                         clock_written,
  input logic [ebta_pkg::PclkW-1:0]   pixel_clock_khz,
  input logic [ebta_pkg::HtotW-1:0]   horiz_total,
  input logic [ebta_pkg::HsyncW-1:0]  hsync_begin,
  input logic [ebta_pkg::VtotW-1:0]   vert_total,
  input logic [ebta_pkg::VtotW-1:0]   vsync_begin
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (status != ebta_pkg::StOk) |->
      !clock_written && pixel_clock_khz == '0 && horiz_total == '0 &&
      hsync_begin == '0 && vert_total == '0 && vsync_begin == '0)
    else $error("failed item carries timing");

  a_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && clock_written |-> status == ebta_pkg::StOk && pixel_clock_khz != '0)
    else $error("pixel clock written on a failed item");

  a_vsync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> vsync_begin <= vert_total)
    else $error("sync start beyond vertical total");

endmodule

bind encoder_blank_timing_adjust_top ebta_checker u_ebta_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .status          (rsp_o.status),
  .clock_written   (rsp_o.clock_written),
  .pixel_clock_khz (rsp_o.pixel_clock_khz),
  .horiz_total     (rsp_o.horiz_total),
  .hsync_begin     (rsp_o.hsync_begin),
  .vert_total      (rsp_o.vert_total),
  .vsync_begin     (rsp_o.vsync_begin)
);

FILE: sim/ebta_tb_if.sv
`timescale 1ns / 1ps
// The block's own interfaces (ebta_req_if, ebta_rsp_if) are used directly.
// This file holds the item types that the testbench exchanges between processes.
package ebta_tb_pkg;
  import ebta_pkg::*;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [WidthW-1:0]  active_width;
    logic [HeightW-1:0] active_height;
    logic [RateW-1:0]   frame_rate;
    logic [VswW-1:0]    vsync_lines;
  } timing_req_t;

  typedef struct packed {
    status_e           status;
    logic              clock_written;
    logic [PclkW-1:0]  pixel_clock_khz;
    logic [HtotW-1:0]  horiz_total;
    logic [HsyncW-1:0] hsync_begin;
    logic [VtotW-1:0]  vert_total;
    logic [VtotW-1:0]  vsync_begin;
  } timing_rsp_t;
endpackage

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ebta_pkg::*;
  import ebta_tb_pkg::*;

  localparam int unsigned NumRandom = 900;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned LongHold = 200;

  logic clk_i;
  logic rst_ni;

  ebta_req_if req_if ();
  ebta_rsp_if rsp_if ();

  encoder_blank_timing_adjust_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  timing_req_t pending_reqs[$];
  timing_rsp_t expected_timings[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit stim_done;
  bit calm_phase;
  bit hold_active;
  bit hold_done;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_count;
  int unsigned accepted_reqs;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sync_start_of(logic [31:0] vtot, logic [31:0] vsw);
    logic [31:0] sub;
    sub = vsw + 32'd4;
    return (vtot > sub) ? vtot - sub : 32'd0;
  endfunction

  function automatic timing_rsp_t predict_timing(timing_req_t rq);
    timing_rsp_t rs;
    logic [31:0] pclk, ht_vb, ht_wl, hs, vblank, w, ht, nv, nh, rate;
    logic [63:0] prod;
    rs = '0;
    rs.status = StOk;
    w = 32'(rq.active_width);
    rate = 32'(rq.frame_rate);
    if (w <= 32'(MaxWidthSd)) begin
      pclk = 74250; ht_vb = 900; ht_wl = 900; hs = 760; vblank = 30;
    end else if (w <= 32'(MaxWidthHd)) begin
      pclk = 148500; ht_vb = 1800; ht_wl = 1800; hs = 1390; vblank = 30;
    end else begin
      pclk = 148500; ht_vb = 2200; ht_wl = 3000; hs = 2008; vblank = 45;
    end
    if (w > 32'(MaxWidthFhd)) begin
      rs.status = StWide;
    end else if (rate == 0) begin
      rs.status = StZeroRate;
    end else if (rq.mode == ModeHblank) begin
      nv = 32'(rq.active_height) + vblank;
      nh = (pclk * 1000) / (nv * rate);
      if (nh <= w) begin
        rs.status = StShort;
      end else begin
        rs.horiz_total = nh[HtotW-1:0];
        rs.hsync_begin = hs[HsyncW-1:0];
        rs.vert_total = nv[VtotW-1:0];
        rs.vsync_begin = VtotW'(sync_start_of(nv, 32'(rq.vsync_lines)));
      end
    end else begin
      ht = (rq.mode == ModeVblank) ? ht_vb : ht_wl;
      nv = (pclk * 1000) / (ht * rate);
      prod = 64'(nv) * 64'(ht) * 64'(rate);
      rs.pixel_clock_khz = PclkW'(prod / 1000);
      rs.clock_written = 1'b1;
      rs.horiz_total = ht[HtotW-1:0];
      rs.hsync_begin = hs[HsyncW-1:0];
      rs.vert_total = nv[VtotW-1:0];
      rs.vsync_begin = VtotW'(sync_start_of(nv, 32'(rq.vsync_lines)));
    end
    return rs;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic timing_req_t make_req(int mode, int w, int h, int rate, int vsw);
    timing_req_t rq;
    rq.mode = ModeW'(mode);
    rq.active_width = WidthW'(w);
    rq.active_height = HeightW'(h);
    rq.frame_rate = RateW'(rate);
    rq.vsync_lines = VswW'(vsw);
    return rq;
  endfunction

  // Directed cases, then random items biased toward valid widths and real refresh rates.
  initial begin
    timing_req_t rq;
    int sel;
    pending_reqs.push_back(make_req(0, 0, 0, 1, 0));
    pending_reqs.push_back(make_req(0, 720, 1080, 60, 5));
    pending_reqs.push_back(make_req(1, 720, 480, 60, 5));
    pending_reqs.push_back(make_req(2, 1280, 720, 60, 5));
    pending_reqs.push_back(make_req(3, 1920, 1080, 60, 5));
    pending_reqs.push_back(make_req(2, 1920, 1080, 30, 1023));
    pending_reqs.push_back(make_req(0, 1921, 1080, 60, 5));
    pending_reqs.push_back(make_req(1, 8191, 8191, 255, 1023));
    pending_reqs.push_back(make_req(1, 1920, 1080, 0, 5));
    pending_reqs.push_back(make_req(1, 1920, 8191, 255, 5));
    pending_reqs.push_back(make_req(1, 721, 1080, 120, 1023));
    pending_reqs.push_back(make_req(0, 1281, 0, 255, 1023));
    pending_reqs.push_back(make_req(2, 0, 8191, 1, 0));
    pending_reqs.push_back(make_req(1, 0, 0, 1, 1023));
    pending_reqs.push_back(make_req(3, 8191, 0, 0, 0));
    pending_reqs.push_back(make_req(0, 1920, 1080, 255, 0));
    for (int i = 0; i < NumRandom; i++) begin
      rq = timing_req_t'({$urandom, $urandom});
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        rq.active_width = WidthW'($urandom_range(0, 1920));
        if (sel < 6) rq.frame_rate = RateW'($urandom_range(1, 120));
        if (sel < 4) rq.active_height = HeightW'($urandom_range(0, 2200));
      end
      pending_reqs.push_back(rq);
    end
  end

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= '0;
      req_if.active_width <= '0;
      req_if.active_height <= '0;
      req_if.frame_rate <= '0;
      req_if.vsync_lines <= '0;
      send_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_timings.push_back(predict_timing({req_if.mode, req_if.active_width,
            req_if.active_height, req_if.frame_rate, req_if.vsync_lines}));
        accepted_reqs <= accepted_reqs + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (!calm_phase && $urandom_range(0, 7) == 0) begin
            // The cycle that starts a gap is idle as well.
            send_gap <= $urandom_range(0, 12);
            req_if.valid <= 1'b0;
          end else begin
            {req_if.mode, req_if.active_width, req_if.active_height, req_if.frame_rate,
             req_if.vsync_lines} <= pending_reqs.pop_front();
            req_if.valid <= 1'b1;
          end
        end else begin
          req_if.valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    timing_rsp_t got, want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_gap <= 0;
      hold_count <= 0;
      hold_active <= 1'b0;
      hold_done <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = {status_e'(rsp_if.status), rsp_if.clock_written, rsp_if.pixel_clock_khz,
               rsp_if.horiz_total, rsp_if.hsync_begin, rsp_if.vert_total,
               rsp_if.vsync_begin};
        if (expected_timings.size() == 0) begin
          report_mismatch("unexpected result, status", got.status, 0);
        end else begin
          want = expected_timings.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.clock_written != want.clock_written)
            report_mismatch("clock_written", got.clock_written, want.clock_written);
          if (got.pixel_clock_khz != want.pixel_clock_khz)
            report_mismatch("pixel_clock_khz", got.pixel_clock_khz, want.pixel_clock_khz);
          if (got.horiz_total != want.horiz_total)
            report_mismatch("horiz_total", got.horiz_total, want.horiz_total);
          if (got.hsync_begin != want.hsync_begin)
            report_mismatch("hsync_begin", got.hsync_begin, want.hsync_begin);
          if (got.vert_total != want.vert_total)
            report_mismatch("vert_total", got.vert_total, want.vert_total);
          if (got.vsync_begin != want.vsync_begin)
            report_mismatch("vsync_begin", got.vsync_begin, want.vsync_begin);
        end
      end
      // One long hold-off early on lets the pipeline and its input queue fill up.
      if (!hold_done && !hold_active && accepted_reqs >= 100) begin
        hold_active <= 1'b1;
        hold_done <= 1'b1;
        hold_count <= LongHold;
        rsp_if.ready <= 1'b0;
      end else if (hold_active) begin
        if (hold_count == 1) hold_active <= 1'b0;
        hold_count <= hold_count - 1;
        rsp_if.ready <= (hold_count == 1);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_if.ready <= (recv_gap == 1);
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 13);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    calm_phase <= (pending_reqs.size() < 150) && (accepted_reqs > 0);
  end

  initial begin
    mismatch_count = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    calm_phase = 1'b0;
    accepted_reqs = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (stim_done && expected_timings.size() == 0);
        repeat (40) @(posedge clk_i);
        if (mismatch_count == 0 && expected_timings.size() == 0) begin
          $display("testbench OK");
        end else begin
          $display("testbench NOT OK");
        end
      end
      begin
        wait (idle_cycles >= IdleLimit);
        $display("timeout with %0d results outstanding", expected_timings.size());
        $display("testbench NOT OK");
      end
    join_any
    $finish;
  end

endmodule
